>>> design/u8sv_pkg.sv
// Shared types and constants for the UTF-8 segment validator.
// Holds the status codes, sequence classes and byte/code point limits.
// No dependencies.
`default_nettype none

package u8sv_pkg;

	// Per-byte result code
	typedef enum logic [1:0] {
		ST_RUNNING = 2'd0,
		ST_VALID   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Length class of the sequence being assembled; sets the overlong floor
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_2B   = 2'd1,
		CLS_3B   = 2'd2,
		CLS_4B   = 2'd3
	} cls_t;

	localparam int unsigned CP_W = 21;

	// Forbidden single bytes
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;

	// Lead byte ranges
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	// Continuation byte tag in the top two bits
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Code point limits
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SUR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SUR_HI = 21'h00DFFF;

	// Smallest code point that a sequence of the given class may encode
	function automatic logic [CP_W-1:0] class_min(input cls_t cls);
		logic [CP_W-1:0] m;
		unique case (cls)
			CLS_2B:   m = 21'h000080;
			CLS_3B:   m = 21'h000800;
			CLS_4B:   m = 21'h010000;
			default:  m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> design/u8sv_core.sv
// Decoder state and per-byte check for the UTF-8 segment validator.
// Updates the sequence state on each step and reports the byte's status.
// Depends on u8sv_pkg.
`default_nettype none

module u8sv_core
	import u8sv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,       // one byte is consumed this cycle
	input  wire logic [7:0] data_byte,
	input  wire logic       seg_last,
	output status_t         status
);

	logic [1:0]      pend_q, pend_d, pend_dec;
	logic [CP_W-1:0] acc_q, acc_d, cp_cont;
	cls_t            cls_q, cls_d;
	logic            err_q, err_d;
	logic            brk;

	// Next state for one byte
	always_comb begin
		brk      = 1'b0;
		pend_d   = pend_q;
		acc_d    = acc_q;
		cls_d    = cls_q;
		cp_cont  = {acc_q[CP_W-7:0], data_byte[5:0]};
		pend_dec = pend_q - 2'd1;
		if (!err_q) begin
			if (pend_q == 2'd0) begin
				priority if (data_byte == BYTE_NUL || data_byte == BYTE_CR ||
				             data_byte == BYTE_LF) begin
					brk = 1'b1;
				end else if (!data_byte[7]) begin
					brk = 1'b0;
				end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
					pend_d = 2'd1;
					acc_d  = {{(CP_W-5){1'b0}}, data_byte[4:0]};
					cls_d  = CLS_2B;
				end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
					pend_d = 2'd2;
					acc_d  = {{(CP_W-4){1'b0}}, data_byte[3:0]};
					cls_d  = CLS_3B;
				end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
					pend_d = 2'd3;
					acc_d  = {{(CP_W-3){1'b0}}, data_byte[2:0]};
					cls_d  = CLS_4B;
				end else begin
					// C0, C1, F5-FF or a stray continuation byte
					brk = 1'b1;
				end
			end else if (data_byte[7:6] != CONT_TAG) begin
				brk = 1'b1;
			end else begin
				acc_d  = cp_cont;
				pend_d = pend_dec;
				// sequence complete: overlong, range and surrogate checks
				if (pend_dec == 2'd0) begin
					brk = (cp_cont < class_min(cls_q)) || (cp_cont > CP_MAX) ||
					      (cp_cont >= CP_SUR_LO && cp_cont <= CP_SUR_HI);
				end
			end
		end
		// segment ending inside a sequence is rejected too
		err_d = err_q | brk | (seg_last && pend_d != 2'd0);
	end

	// Status of this byte
	always_comb begin
		if (err_d) begin
			status = ST_INVALID;
		end else if (seg_last) begin
			status = ST_VALID;
		end else begin
			status = ST_RUNNING;
		end
	end

	// State registers; all clear after the last byte of a segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			acc_q  <= '0;
			cls_q  <= CLS_NONE;
			err_q  <= 1'b0;
		end else if (step) begin
			if (seg_last) begin
				pend_q <= 2'd0;
				acc_q  <= '0;
				cls_q  <= CLS_NONE;
				err_q  <= 1'b0;
			end else begin
				pend_q <= pend_d;
				acc_q  <= acc_d;
				cls_q  <= cls_d;
				err_q  <= err_d;
			end
		end
	end

	// Segment end leaves a clean state
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && seg_last |=> pend_q == 2'd0 && !err_q)
		else $error("state not cleared after segment end");

	// Pending count never exceeds the length class of the open sequence
	a_pend_le_cls: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= cls_q)
		else $error("pending count exceeds sequence class");

	// Valid status only on a segment's last byte
	a_valid_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && !seg_last |-> status != ST_VALID)
		else $error("valid status before segment end");

	// A latched rejection reports invalid until the segment ends
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && err_q |-> status == ST_INVALID)
		else $error("latched rejection not reported");

endmodule

`default_nettype wire

>>> design/utf8_segment_validator_top.sv
// Top level of the UTF-8 segment validator: stream ports, input and
// result registers around the per-byte check.
// Depends on u8sv_pkg and u8sv_core.
//
// Usage:
//   The slave channel (s_*) takes one byte of a text segment per request,
//   with s_tlast on the segment's final byte. The master channel (m_*)
//   returns one result per byte: the status in m_tdata and the echoed end
//   marker in m_tlast. Status is 0 while the segment is fine so far, 1 on
//   the final byte of a valid segment, 2 from the first offending byte on.
//   The byte is first registered in the input register, then checked
//   against the decoder state and registered in the result register.
//   Throughput is one byte per cycle while the receiver does not stall;
//   the decoder state update is a single short compare/shift step per byte.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; then s_tready drops until m_tready
//   returns. No request is lost or repeated.
//   Reset clears the valid flags and the decoder state, so the first byte
//   after reset starts a new segment.
`default_nettype none

module utf8_segment_validator_top
	import u8sv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] data_byte
	input  wire logic       s_tlast,    // segment_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,    // [1:0] status, [7:2] zero
	output logic            m_tlast     // segment_end
);

	logic       valid_s1, last_s1;
	logic [7:0] byte_s1;
	logic       valid_s2, end_s2;
	status_t    status_s2, status_c;
	logic       out_free, adv;

	// Pipeline control
	assign out_free = !valid_s2 || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	u8sv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (byte_s1),
		.seg_last  (last_s1),
		.status    (status_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_c;
			end_s2    <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, status_s2};
	assign m_tlast  = end_s2;

	// Input side only stalls when both stages are full and output is blocked
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a full pipeline");

	// A byte that cannot advance stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a byte");

	// Every advancing byte lands in the result register
	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result register missed a byte");

endmodule

`default_nettype wire
